[design/afc_pkg.sv]
`timescale 1ns / 1ps

package afc_pkg;

    localparam logic [7:0] CRC_POLY     = 8'h2F;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam int         CRC_BYTES    = 7;
    localparam int         COUNTER_W    = 6;
    localparam int         ERROR_W      = 32;
    localparam int         ANGLE_W      = 16;
    localparam int         DIAG_W       = 2;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_MARKER   = 3'd1,
        STATUS_RESERVED = 3'd2,
        STATUS_GAIN     = 3'd3,
        STATUS_CRC      = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte3;
        logic [7:0] frame_byte4;
        logic [7:0] frame_byte5;
        logic [7:0] frame_byte6;
        logic [7:0] frame_byte7;
    } frame_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ANGLE_W-1:0] angle;
        logic [DIAG_W-1:0]  diagnostic;
        logic [ERROR_W-1:0] error_total;
    } result_t;

    typedef struct packed {
        logic [COUNTER_W-1:0] rolling_counter;
        logic [ERROR_W-1:0]   error_count;
        logic [ANGLE_W-1:0]   held_angle;
        logic [DIAG_W-1:0]    held_diagnostic;
    } track_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/afc_crc.sv]
`timescale 1ns / 1ps

module afc_crc (
    input  afc_pkg::frame_t frame,
    output logic            crc_ok
);
    import afc_pkg::*;

    logic [7:0] crc;

    always_comb begin
        crc = CRC_INIT;
        crc = crc8_byte(crc, frame.frame_byte0);
        crc = crc8_byte(crc, frame.frame_byte1);
        crc = crc8_byte(crc, frame.frame_byte2);
        crc = crc8_byte(crc, frame.frame_byte3);
        crc = crc8_byte(crc, frame.frame_byte4);
        crc = crc8_byte(crc, frame.frame_byte5);
        crc = crc8_byte(crc, frame.frame_byte6);
        crc_ok = (frame.frame_byte7 == ~crc);
    end

endmodule

[design/afc_check.sv]
`timescale 1ns / 1ps

module afc_check (
    input  afc_pkg::frame_t  frame,
    input  logic             crc_ok,
    input  afc_pkg::track_t  track,
    output afc_pkg::track_t  track_next,
    output afc_pkg::result_t result
);
    import afc_pkg::*;

    status_t              status;
    logic                 early_pass;
    logic [COUNTER_W-1:0] counter;
    logic [COUNTER_W-1:0] gap;
    logic [COUNTER_W-1:0] lost;
    logic [COUNTER_W-1:0] error_inc;

    assign counter = frame.frame_byte6[COUNTER_W-1:0];
    assign gap     = counter - track.rolling_counter;
    assign lost    = (gap > COUNTER_W'(1)) ? gap - COUNTER_W'(1) : '0;

    always_comb begin
        early_pass = 1'b0;
        if (frame.frame_byte6[7:6] != 2'b00) begin
            status = STATUS_MARKER;
        end else if (frame.frame_byte2 != 8'h00 || frame.frame_byte3 != 8'h00
                     || frame.frame_byte5 != 8'h00) begin
            status = STATUS_RESERVED;
        end else if (frame.frame_byte4 == 8'h00) begin
            status = STATUS_GAIN;
        end else begin
            early_pass = 1'b1;
            status     = crc_ok ? STATUS_OK : STATUS_CRC;
        end
    end

    // lost frames never exceed 62, so one more still fits
    assign error_inc = (early_pass ? lost : '0)
                     + COUNTER_W'(status != STATUS_OK);

    always_comb begin
        track_next                 = track;
        track_next.error_count     = track.error_count + ERROR_W'(error_inc);
        if (early_pass) begin
            track_next.rolling_counter = counter;
        end
        if (status == STATUS_OK) begin
            track_next.held_angle      = {frame.frame_byte1[5:0], frame.frame_byte0, 2'b00};
            track_next.held_diagnostic = frame.frame_byte1[7:6];
        end
    end

    always_comb begin
        result.status      = status;
        result.angle       = track_next.held_angle;
        result.diagnostic  = track_next.held_diagnostic;
        result.error_total = track_next.error_count;
    end

endmodule

[design/angle_sensor_frame_checker.sv]
`timescale 1ns / 1ps
// A request lands in the input register on acceptance and moves into the result register once
// the output register is empty or its result is being taken.
// Throughput: one request per cycle; while a result waits, one more request is held in the
// input register and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, counter, error count and held data zero.
module angle_sensor_frame_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  afc_pkg::frame_t  s_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output afc_pkg::result_t m_result
);
    import afc_pkg::*;

    logic    in_valid_reg;
    frame_t  frame_reg;
    logic    out_valid_reg;
    result_t result_reg;
    track_t  track_reg;
    track_t  track_next;
    result_t result_next;
    logic    crc_ok;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_result = result_reg;

    afc_crc u_crc (
        .frame  (frame_reg),
        .crc_ok (crc_ok)
    );

    afc_check u_check (
        .frame      (frame_reg),
        .crc_ok     (crc_ok),
        .track      (track_reg),
        .track_next (track_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            track_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                track_reg     <= track_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            frame_reg <= s_frame;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule

[tb/afc_result_monitor.sv]
`timescale 1ns / 1ps

module afc_result_monitor (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  afc_pkg::frame_t  s_frame,
    input  logic             m_valid,
    input  logic             m_ready,
    input  afc_pkg::result_t m_result,
    output int               fail_count,
    output int               compared,
    output int               outstanding
);
    import afc_pkg::*;

    logic [COUNTER_W-1:0] last_counter;
    logic [ERROR_W-1:0]   bad_frames;
    logic [ANGLE_W-1:0]   angle_q;
    logic [DIAG_W-1:0]    diag_q;
    result_t              pending_results[$];

    function automatic logic [7:0] frame_crc(input frame_t f);
        logic [55:0] body;
        logic [7:0]  acc;
        logic        fb;
        body = f[63:8];
        acc = CRC_INIT;
        for (int i = 55; i >= 0; i--) begin
            fb = acc[7] ^ body[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return ~acc;
    endfunction

    // advance the tracked state by one request and return the result it yields
    function automatic result_t check_frame(input frame_t f);
        result_t              r;
        status_t              verdict;
        logic [COUNTER_W-1:0] gap;
        verdict = STATUS_OK;
        if (f.frame_byte6[7:6] != 2'b00) begin
            verdict = STATUS_MARKER;
        end else if ((f.frame_byte2 | f.frame_byte3 | f.frame_byte5) != 8'h00) begin
            verdict = STATUS_RESERVED;
        end else if (f.frame_byte4 == 8'h00) begin
            verdict = STATUS_GAIN;
        end else begin
            gap = f.frame_byte6[5:0] - last_counter;
            if (gap > 6'd1) begin
                bad_frames = bad_frames + {26'd0, gap} - 32'd1;
            end
            last_counter = f.frame_byte6[5:0];
            if (f.frame_byte7 != frame_crc(f)) begin
                verdict = STATUS_CRC;
            end else begin
                angle_q = {f.frame_byte1[5:0], f.frame_byte0, 2'b00};
                diag_q = f.frame_byte1[7:6];
            end
        end
        if (verdict != STATUS_OK) begin
            bad_frames = bad_frames + 32'd1;
        end
        r.status = verdict;
        r.angle = angle_q;
        r.diagnostic = diag_q;
        r.error_total = bad_frames;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, label, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            last_counter = '0;
            bad_frames = '0;
            angle_q = '0;
            diag_q = '0;
            fail_count = 0;
            compared = 0;
            pending_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(check_frame(s_frame));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result expected none got %0h", $time, m_result);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_result.status));
                    check_field("angle", 32'(want.angle), 32'(m_result.angle));
                    check_field("diagnostic", 32'(want.diagnostic),
                                32'(m_result.diagnostic));
                    check_field("error_total", want.error_total, m_result.error_total);
                    compared++;
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

[tb/angle_sensor_frame_checker_test.sv]
`timescale 1ns / 1ps

module angle_sensor_frame_checker_test;
    import afc_pkg::*;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    frame_t  s_frame;
    logic    m_valid;
    logic    m_ready;
    result_t m_result;
    int      fail_count;
    int      compared;
    int      outstanding;

    int          sent;
    int          well_formed;
    bit          tx_burst;
    bit          rx_burst;
    int          rx_hold;
    logic [5:0]  tx_counter;

    angle_sensor_frame_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_frame  (s_frame),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    afc_result_monitor chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame     (s_frame),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .fail_count  (fail_count),
        .compared    (compared),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // hold off the result channel at random after each result taken, except in burst mode
    initial begin
        m_ready <= 1'b0;
        rx_hold = 0;
        rx_burst = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if ($urandom_range(0, 63) == 0) begin
                    rx_burst = ~rx_burst;
                end
                rx_hold = rx_burst ? 0 : $urandom_range(0, 9);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic frame_t seal(input frame_t f);
        logic [7:0] acc;
        logic       fb;
        acc = CRC_INIT;
        for (int i = 63; i >= 8; i--) begin
            fb = acc[7] ^ f[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        f.frame_byte7 = ~acc;
        return f;
    endfunction

    function automatic frame_t good_frame(input logic [5:0] cnt);
        frame_t f;
        f = '0;
        f.frame_byte0 = 8'($urandom);
        f.frame_byte1 = 8'($urandom);
        f.frame_byte4 = 8'($urandom_range(1, 255));
        f.frame_byte6 = {2'b00, cnt};
        return seal(f);
    endfunction

    task automatic send_frame(input frame_t f);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_frame <= f;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        frame_t f;
        int     kind;
        s_valid <= 1'b0;
        s_frame <= '0;
        aresetn <= 1'b0;
        sent = 0;
        well_formed = 0;
        tx_burst = 1'b0;
        tx_counter = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        f = seal({8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00});
        send_frame(f);
        f = seal({8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h02, 8'h00});
        send_frame(f);
        f = good_frame(6'd3);
        f.frame_byte6 = 8'h42;
        send_frame(f);
        f.frame_byte6 = 8'h83;
        send_frame(f);
        send_frame({8{8'hFF}});
        f = good_frame(6'd3);
        f.frame_byte2 = 8'hFF;
        send_frame(f);
        f = good_frame(6'd3);
        f.frame_byte3 = 8'h01;
        send_frame(f);
        f = good_frame(6'd3);
        f.frame_byte5 = 8'h80;
        send_frame(f);
        f = good_frame(6'd3);
        f.frame_byte4 = 8'h00;
        send_frame(seal(f));
        send_frame('0);
        f = good_frame(6'd3);
        f.frame_byte6 = 8'hC0;
        f.frame_byte2 = 8'h01;
        send_frame(f);
        f = good_frame(6'd3);
        f.frame_byte5 = 8'h01;
        f.frame_byte4 = 8'h00;
        send_frame(f);
        send_frame(good_frame(6'd2));
        f = good_frame(6'd12);
        f.frame_byte7 = ~f.frame_byte7;
        send_frame(f);
        send_frame(good_frame(6'd63));
        send_frame(good_frame(6'd0));
        send_frame(good_frame(6'd63));
        f = good_frame(6'd63);
        f.frame_byte7 = f.frame_byte7 ^ 8'h01;
        send_frame(f);
        f = good_frame(6'd0);
        f.frame_byte0 = 8'h55;
        f.frame_byte1 = 8'hAA;
        send_frame(seal(f));
        f = good_frame(6'd1);
        f.frame_byte1 = 8'h40;
        send_frame(seal(f));
        tx_counter = 6'd1;
        drain();

        for (int n = 0; n < 1150; n++) begin
            if (n % 50 == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
            end
            if (n == 575) begin
                drain();
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                case ($urandom_range(0, 9))
                    0:       tx_counter = 6'($urandom);
                    1:       ;
                    default: tx_counter = tx_counter + 6'd1;
                endcase
                f = good_frame(tx_counter);
                if (kind >= 55) begin
                    f.frame_byte7 = f.frame_byte7 ^ 8'($urandom_range(1, 255));
                end
                well_formed++;
            end else begin
                f = good_frame(tx_counter + 6'd1);
                if (kind < 80) begin
                    f.frame_byte6[7:6] = 2'($urandom_range(1, 3));
                end else if (kind < 88) begin
                    case ($urandom_range(0, 2))
                        0:       f.frame_byte2 = 8'($urandom_range(1, 255));
                        1:       f.frame_byte3 = 8'($urandom_range(1, 255));
                        default: f.frame_byte5 = 8'($urandom_range(1, 255));
                    endcase
                end else if (kind < 92) begin
                    f.frame_byte4 = 8'h00;
                    f = seal(f);
                end else begin
                    f = {$urandom, $urandom};
                end
            end
            send_frame(f);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("summary: %0d frames sent (%0d well-formed, rest malformed or noise)",
                 sent, well_formed);
        $display("summary: %0d results compared, %0d mismatches", compared, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
